/* sv/dqsc_pkg.sv */
// ----------------------------------------------------------------------------
// dqsc_pkg
// Shared constants for the dual quadrature speed counter.
// ----------------------------------------------------------------------------
package dqsc_pkg;

   localparam int WINDOW_WIDTH_DEF = 16;
   localparam int TOTAL_WIDTH_DEF  = 32;

   localparam int KIND_WIDTH  = 2;
   localparam int PINS_WIDTH  = 4;

   typedef logic [KIND_WIDTH-1:0] kind_type;

   // word kinds
   localparam kind_type KIND_EDGE  = 2'd0;
   localparam kind_type KIND_TICK  = 2'd1;
   localparam kind_type KIND_CLEAR = 2'd2;

   // bit positions in edge_flags / pin_levels
   localparam int BIT_A1 = 0;
   localparam int BIT_B1 = 1;
   localparam int BIT_A2 = 2;
   localparam int BIT_B2 = 3;

endpackage

/* sv/dual_quadrature_speed_counter_unit.sv */
// ----------------------------------------------------------------------------
// dual_quadrature_speed_counter_unit
// Two-wheel quadrature edge counter with windowed speed and saturating totals.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per event: kind (edge event, sampling tick or
//   clear), the pending edge flags and the current pin levels. The word is
//   taken at a rising edge with req_valid high and req_stall low.
//   rsp_* returns one word for every request word: both latched speeds,
//   both running totals and their average (truncated toward zero).
//   A rsp word is taken at a rising edge with rsp_valid high, rsp_stall low.
// Timing:
//   The counter state is updated at the edge that takes the request; the
//   response register loads from it once the response side is free. One
//   request per cycle is sustained while rsp_stall is low, set by the single
//   state-update stage followed by the response register.
// Stall:
//   When rsp_stall holds, the response word stays put; an empty state stage
//   still takes one more request, then req_stall rises until the response drains.
// Reset:
//   Synchronous reset zeroes all counters, latched speeds and totals and empties both stages.
// ----------------------------------------------------------------------------
module dual_quadrature_speed_counter_unit #(
   parameter int WINDOW_WIDTH = dqsc_pkg::WINDOW_WIDTH_DEF,
   parameter int TOTAL_WIDTH  = dqsc_pkg::TOTAL_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [dqsc_pkg::KIND_WIDTH-1:0] req_kind,
   input  logic [dqsc_pkg::PINS_WIDTH-1:0] req_edge_flags,
   input  logic [dqsc_pkg::PINS_WIDTH-1:0] req_pin_levels,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [WINDOW_WIDTH-1:0]  rsp_speed_first,
   output logic signed [WINDOW_WIDTH-1:0]  rsp_speed_second,
   output logic signed [TOTAL_WIDTH-1:0]   rsp_total_first,
   output logic signed [TOTAL_WIDTH-1:0]   rsp_total_second,
   output logic signed [TOTAL_WIDTH-1:0]   rsp_average_total
);

   localparam int W     = WINDOW_WIDTH;
   localparam int T     = TOTAL_WIDTH;
   localparam int SUM_W = ((W > T) ? W : T) + 1;

   localparam logic signed [W-1:0] WMAX  = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN  = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] WONE  = {{(W-1){1'b0}}, 1'b1};
   localparam logic signed [T-1:0] TMAX  = {1'b0, {(T-1){1'b1}}};
   localparam logic signed [T-1:0] TMIN  = {1'b1, {(T-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] TMAX_S = SUM_W'(TMAX);
   localparam logic signed [SUM_W-1:0] TMIN_S = SUM_W'(TMIN);

   function automatic logic signed [W-1:0] win_step(input logic signed [W-1:0] v,
                                                    input logic up);
      if (up) begin
         return (v == WMAX) ? WMAX : v + WONE;
      end
      return (v == WMIN) ? WMIN : v - WONE;
   endfunction

   // phase-A edge wins over phase-B edge of the same wheel
   function automatic logic signed [W-1:0] decode(input logic signed [W-1:0] v,
                                                  input logic ea, input logic eb,
                                                  input logic la, input logic lb);
      if (ea) begin
         return win_step(v, lb);
      end
      if (eb) begin
         return win_step(v, !la);
      end
      return v;
   endfunction

   function automatic logic signed [T-1:0] sat_add(input logic signed [T-1:0] acc,
                                                   input logic signed [W-1:0] s);
      logic signed [SUM_W-1:0] sum;
      sum = SUM_W'(acc) + SUM_W'(s);
      if (sum > TMAX_S) begin
         return TMAX;
      end
      if (sum < TMIN_S) begin
         return TMIN;
      end
      return T'(sum);
   endfunction

   // state stage
   logic                  st_valid_ff, st_valid_in;
   logic signed [W-1:0]   window_first_ff, window_first_in;
   logic signed [W-1:0]   window_second_ff, window_second_in;
   logic signed [W-1:0]   latched_first_ff, latched_first_in;
   logic signed [W-1:0]   latched_second_ff, latched_second_in;
   logic signed [T-1:0]   accum_first_ff, accum_first_in;
   logic signed [T-1:0]   accum_second_ff, accum_second_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]   rsp_speed_first_ff, rsp_speed_second_ff;
   logic signed [T-1:0]   rsp_total_first_ff, rsp_total_second_ff, rsp_average_ff;

   logic                  out_ready;
   logic                  st_move;
   logic                  st_ready;
   logic                  req_accept;
   logic signed [W-1:0]   speed_second_neg;
   logic signed [T:0]     pair_sum;
   logic signed [T:0]     pair_half;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign st_move    = st_valid_ff && out_ready;
   assign st_ready   = !st_valid_ff || out_ready;
   assign req_accept = req_valid && st_ready;
   assign req_stall  = !st_ready;

   // negating the most negative count saturates
   assign speed_second_neg = (window_second_ff == WMIN) ? WMAX : -window_second_ff;

   always_comb begin
      window_first_in   = window_first_ff;
      window_second_in  = window_second_ff;
      latched_first_in  = latched_first_ff;
      latched_second_in = latched_second_ff;
      accum_first_in    = accum_first_ff;
      accum_second_in   = accum_second_ff;
      if (req_accept) begin
         case (req_kind)
            dqsc_pkg::KIND_EDGE: begin
               window_first_in  = decode(window_first_ff,
                                         req_edge_flags[dqsc_pkg::BIT_A1],
                                         req_edge_flags[dqsc_pkg::BIT_B1],
                                         req_pin_levels[dqsc_pkg::BIT_A1],
                                         req_pin_levels[dqsc_pkg::BIT_B1]);
               window_second_in = decode(window_second_ff,
                                         req_edge_flags[dqsc_pkg::BIT_A2],
                                         req_edge_flags[dqsc_pkg::BIT_B2],
                                         req_pin_levels[dqsc_pkg::BIT_A2],
                                         req_pin_levels[dqsc_pkg::BIT_B2]);
            end
            dqsc_pkg::KIND_TICK: begin
               latched_first_in  = window_first_ff;
               latched_second_in = speed_second_neg;
               accum_first_in    = sat_add(accum_first_ff, window_first_ff);
               accum_second_in   = sat_add(accum_second_ff, speed_second_neg);
               window_first_in   = '0;
               window_second_in  = '0;
            end
            dqsc_pkg::KIND_CLEAR: begin
               window_first_in   = '0;
               window_second_in  = '0;
               latched_first_in  = '0;
               latched_second_in = '0;
               accum_first_in    = '0;
               accum_second_in   = '0;
            end
            default: begin
               // unused kind: state holds, current values go out
            end
         endcase
      end
   end

   always_comb begin
      if (req_accept) begin
         st_valid_in = 1'b1;
      end else if (st_move) begin
         st_valid_in = 1'b0;
      end else begin
         st_valid_in = st_valid_ff;
      end
      if (st_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // average truncated toward zero: bias negatives by one before the shift
   assign pair_sum  = (T+1)'(accum_first_ff) + (T+1)'(accum_second_ff);
   assign pair_half = (pair_sum + {{T{1'b0}}, pair_sum[T]}) >>> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         window_first_ff   <= '0;
         window_second_ff  <= '0;
         latched_first_ff  <= '0;
         latched_second_ff <= '0;
         accum_first_ff    <= '0;
         accum_second_ff   <= '0;
      end else begin
         st_valid_ff       <= st_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         window_first_ff   <= window_first_in;
         window_second_ff  <= window_second_in;
         latched_first_ff  <= latched_first_in;
         latched_second_ff <= latched_second_in;
         accum_first_ff    <= accum_first_in;
         accum_second_ff   <= accum_second_in;
      end
   end

   // state regs hold the staged word's values until it moves out
   always_ff @(posedge clock) begin
      if (st_move) begin
         rsp_speed_first_ff  <= latched_first_ff;
         rsp_speed_second_ff <= latched_second_ff;
         rsp_total_first_ff  <= accum_first_ff;
         rsp_total_second_ff <= accum_second_ff;
         rsp_average_ff      <= T'(pair_half);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_speed_first   = rsp_speed_first_ff;
   assign rsp_speed_second  = rsp_speed_second_ff;
   assign rsp_total_first   = rsp_total_first_ff;
   assign rsp_total_second  = rsp_total_second_ff;
   assign rsp_average_total = rsp_average_ff;

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == dqsc_pkg::KIND_CLEAR) |=>
         (window_first_ff == '0 && window_second_ff == '0 &&
          accum_first_ff == '0 && accum_second_ff == '0))
      else $error("clear word did not zero the counters");

   a_tick_clears_window: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == dqsc_pkg::KIND_TICK) |=>
         (window_first_ff == '0 && window_second_ff == '0 &&
          latched_first_ff == $past(window_first_ff)))
      else $error("tick word did not latch and clear the windows");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (st_valid_ff && rsp_valid_ff && rsp_stall) |=> st_valid_ff)
      else $error("staged word lost while response stalled");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (st_valid_ff && rsp_valid_ff))
      else $error("request stalled with room in the pipeline");

   a_move_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      st_move |=> rsp_valid_ff)
      else $error("staged word did not reach the response register");

endmodule

/* verif/dual_quadrature_speed_counter_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_quadrature_speed_counter_unit_test
// Drives edge, tick, clear and unused words into the two-wheel counter, keeps
// a cycle-free model of the windows, latched speeds and totals, and compares
// every response word field by field. Covers decode rules, opposite-direction
// runs on both wheels, drain pauses and random quadrature traffic with idling
// on both sides.
// ----------------------------------------------------------------------------
module dual_quadrature_speed_counter_unit_test;

   localparam int WW = dqsc_pkg::WINDOW_WIDTH_DEF;
   localparam int TW = dqsc_pkg::TOTAL_WIDTH_DEF;

   localparam dqsc_pkg::kind_type KIND_UNUSED = 2'd3;

   localparam logic signed [WW-1:0] WIN_MAX = {1'b0, {(WW-1){1'b1}}};
   localparam logic signed [WW-1:0] WIN_MIN = {1'b1, {(WW-1){1'b0}}};
   localparam logic signed [WW-1:0] WIN_ONE = {{(WW-1){1'b0}}, 1'b1};
   localparam longint TOT_MAX = (longint'(1) << (TW-1)) - 1;
   localparam longint TOT_MIN = -TOT_MAX - 1;

   localparam logic [dqsc_pkg::PINS_WIDTH-1:0] BOTH_A_EDGES =
      dqsc_pkg::PINS_WIDTH'((1 << dqsc_pkg::BIT_A1) | (1 << dqsc_pkg::BIT_A2));
   localparam logic [dqsc_pkg::PINS_WIDTH-1:0] B1_HIGH =
      dqsc_pkg::PINS_WIDTH'(1 << dqsc_pkg::BIT_B1);
   localparam logic [dqsc_pkg::PINS_WIDTH-1:0] B2_HIGH =
      dqsc_pkg::PINS_WIDTH'(1 << dqsc_pkg::BIT_B2);

   typedef struct packed {
      logic [WW-1:0] speed_first;
      logic [WW-1:0] speed_second;
      logic [TW-1:0] total_first;
      logic [TW-1:0] total_second;
      logic [TW-1:0] average_total;
   } wheel_report_type;

   logic clock = 1'b0;
   logic reset;

   logic                            req_valid;
   logic                            req_stall;
   dqsc_pkg::kind_type              req_kind;
   logic [dqsc_pkg::PINS_WIDTH-1:0] req_edge_flags;
   logic [dqsc_pkg::PINS_WIDTH-1:0] req_pin_levels;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [WW-1:0]  rsp_speed_first;
   logic signed [WW-1:0]  rsp_speed_second;
   logic signed [TW-1:0]  rsp_total_first;
   logic signed [TW-1:0]  rsp_total_second;
   logic signed [TW-1:0]  rsp_average_total;

   // model state
   logic signed [WW-1:0] win_first, win_second;
   logic signed [WW-1:0] lat_first, lat_second;
   logic signed [TW-1:0] tot_first, tot_second;

   wheel_report_type expected_reports[$];
   int  mismatches = 0;
   bit  idle_on = 1'b0;
   int  stall_left = 0;

   dual_quadrature_speed_counter_unit #(
      .WINDOW_WIDTH(WW),
      .TOTAL_WIDTH (TW)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_edge_flags   (req_edge_flags),
      .req_pin_levels   (req_pin_levels),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_speed_first  (rsp_speed_first),
      .rsp_speed_second (rsp_speed_second),
      .rsp_total_first  (rsp_total_first),
      .rsp_total_second (rsp_total_second),
      .rsp_average_total(rsp_average_total)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------- model ----------------

   function automatic logic signed [WW-1:0] count_step(logic signed [WW-1:0] v, bit up);
      if (up) return (v == WIN_MAX) ? v : v + WIN_ONE;
      return (v == WIN_MIN) ? v : v - WIN_ONE;
   endfunction

   // A edge wins over B edge; direction comes from the other phase's level
   function automatic logic signed [WW-1:0] decode_wheel(logic signed [WW-1:0] v,
                                                         bit ea, bit eb, bit la, bit lb);
      if (ea) return count_step(v, lb);
      if (eb) return count_step(v, !la);
      return v;
   endfunction

   function automatic logic signed [TW-1:0] total_add(logic signed [TW-1:0] acc,
                                                      logic signed [WW-1:0] s);
      longint sum;
      sum = longint'(acc) + longint'(s);
      if (sum > TOT_MAX) return TW'(TOT_MAX);
      if (sum < TOT_MIN) return TW'(TOT_MIN);
      return TW'(sum);
   endfunction

   function automatic void clear_counters();
      win_first  = '0;
      win_second = '0;
      lat_first  = '0;
      lat_second = '0;
      tot_first  = '0;
      tot_second = '0;
   endfunction

   function automatic wheel_report_type advance_counters(dqsc_pkg::kind_type k,
                                                         logic [dqsc_pkg::PINS_WIDTH-1:0] ef,
                                                         logic [dqsc_pkg::PINS_WIDTH-1:0] pl);
      wheel_report_type r;
      longint pair;
      case (k)
         dqsc_pkg::KIND_EDGE: begin
            win_first  = decode_wheel(win_first, ef[dqsc_pkg::BIT_A1], ef[dqsc_pkg::BIT_B1],
                                      pl[dqsc_pkg::BIT_A1], pl[dqsc_pkg::BIT_B1]);
            win_second = decode_wheel(win_second, ef[dqsc_pkg::BIT_A2], ef[dqsc_pkg::BIT_B2],
                                      pl[dqsc_pkg::BIT_A2], pl[dqsc_pkg::BIT_B2]);
         end
         dqsc_pkg::KIND_TICK: begin
            lat_first  = win_first;
            lat_second = (win_second == WIN_MIN) ? WIN_MAX : -win_second;
            tot_first  = total_add(tot_first, lat_first);
            tot_second = total_add(tot_second, lat_second);
            win_first  = '0;
            win_second = '0;
         end
         dqsc_pkg::KIND_CLEAR: clear_counters();
         default: ;
      endcase
      pair = longint'(tot_first) + longint'(tot_second);
      r.speed_first   = lat_first;
      r.speed_second  = lat_second;
      r.total_first   = tot_first;
      r.total_second  = tot_second;
      r.average_total = TW'(pair / 2);   // longint division truncates toward zero
      return r;
   endfunction

   // ---------------- response side ----------------

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic compare_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : response_check
      wheel_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: response word with nothing expected", $time);
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            compare_field("speed_first", $signed(want.speed_first), rsp_speed_first);
            compare_field("speed_second", $signed(want.speed_second), rsp_speed_second);
            compare_field("total_first", $signed(want.total_first), rsp_total_first);
            compare_field("total_second", $signed(want.total_second), rsp_total_second);
            compare_field("average_total", $signed(want.average_total), rsp_average_total);
         end
      end
   end

   // ---------------- request side ----------------

   // leaves req_valid high; callers lower it when they pause
   task automatic send_word(dqsc_pkg::kind_type k, logic [dqsc_pkg::PINS_WIDTH-1:0] ef,
                            logic [dqsc_pkg::PINS_WIDTH-1:0] pl);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= k;
      req_edge_flags <= ef;
      req_pin_levels <= pl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_reports.push_back(advance_counters(k, ef, pl));
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // ---------------- tests ----------------

   task automatic test_directed_decode();
      idle_on = 1'b1;
      send_word(dqsc_pkg::KIND_EDGE, 4'b0000, 4'b1111);   // event with no flags
      for (int b = 0; b < dqsc_pkg::PINS_WIDTH; b++) begin
         send_word(dqsc_pkg::KIND_EDGE, dqsc_pkg::PINS_WIDTH'(1 << b), 4'b0000);
         send_word(dqsc_pkg::KIND_EDGE, dqsc_pkg::PINS_WIDTH'(1 << b), 4'b1111);
      end
      // A and B flags both set: the A flag decides
      send_word(dqsc_pkg::KIND_EDGE, 4'b1111, 4'b0101);
      send_word(dqsc_pkg::KIND_EDGE, 4'b1111, 4'b1010);
      send_word(dqsc_pkg::KIND_EDGE, 4'b1111, 4'b1010);
      send_word(dqsc_pkg::KIND_TICK, 4'b1111, 4'b1111);
      send_word(KIND_UNUSED, 4'b1111, 4'b1111);
      send_word(dqsc_pkg::KIND_EDGE, 4'b0011, 4'b1100);
      send_word(dqsc_pkg::KIND_TICK, 4'b0000, 4'b0000);
      send_word(dqsc_pkg::KIND_TICK, 4'b0000, 4'b0000);  // empty windows
      send_word(dqsc_pkg::KIND_EDGE, 4'b1111, 4'b0000);
      send_word(dqsc_pkg::KIND_CLEAR, 4'b1111, 4'b1111);
      send_word(dqsc_pkg::KIND_TICK, 4'b0000, 4'b0000);
      wait_until_drained();
   endtask

   // Runs the wheels in opposite directions, then reverses both. Neither the
   // window bounds nor the total bounds are reached in this run.
   task automatic test_opposite_runs();
      idle_on = 1'b0;
      send_word(dqsc_pkg::KIND_CLEAR, 4'b0000, 4'b0000);
      // first wheel up, second down
      repeat (24) send_word(dqsc_pkg::KIND_EDGE, BOTH_A_EDGES, B1_HIGH);
      send_word(dqsc_pkg::KIND_TICK, 4'b0000, 4'b0000);
      // and the other way round
      repeat (24) send_word(dqsc_pkg::KIND_EDGE, BOTH_A_EDGES, B2_HIGH);
      send_word(dqsc_pkg::KIND_TICK, 4'b0000, 4'b0000);
      send_word(dqsc_pkg::KIND_TICK, 4'b0000, 4'b0000);
      wait_until_drained();
   endtask

   task automatic test_random_traffic(int count);
      logic [dqsc_pkg::PINS_WIDTH-1:0] levels;
      logic [dqsc_pkg::PINS_WIDTH-1:0] flags;
      int pick;
      levels = '0;
      for (int n = 0; n < count; n++) begin
         idle_on = (n < count - 100) && ((n / 64) % 3 != 2);
         if (n % 150 == 149) wait_until_drained();
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            // clean quadrature: at most one pin per wheel toggles
            flags = '0;
            if ($urandom_range(0, 3) != 0) flags[2'($urandom_range(0, 1))] = 1'b1;
            if ($urandom_range(0, 3) != 0) flags[2'(2 + $urandom_range(0, 1))] = 1'b1;
            levels ^= flags;
            send_word(dqsc_pkg::KIND_EDGE, flags, levels);
         end else if (pick < 77) begin
            send_word(dqsc_pkg::KIND_EDGE, dqsc_pkg::PINS_WIDTH'($urandom),
                      dqsc_pkg::PINS_WIDTH'($urandom));
         end else if (pick < 92) begin
            send_word(dqsc_pkg::KIND_TICK, dqsc_pkg::PINS_WIDTH'($urandom),
                      dqsc_pkg::PINS_WIDTH'($urandom));
         end else if (pick < 96) begin
            send_word(dqsc_pkg::KIND_CLEAR, dqsc_pkg::PINS_WIDTH'($urandom),
                      dqsc_pkg::PINS_WIDTH'($urandom));
         end else begin
            send_word(KIND_UNUSED, dqsc_pkg::PINS_WIDTH'($urandom),
                      dqsc_pkg::PINS_WIDTH'($urandom));
         end
      end
      idle_on = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = dqsc_pkg::KIND_EDGE;
      req_edge_flags = '0;
      req_pin_levels = '0;
      clear_counters();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_decode();
      test_opposite_runs();
      test_random_traffic(580);

      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout", $time);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
